@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the text renderer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BTR_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset.
`define BTR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/btr_pkg.sv @@
// ---------------------------------------------------------------------------
// btr_pkg
// Types and constants shared by the bitmap text renderer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package btr_pkg;

  // Character codes with special meaning
  localparam logic [7:0] CHAR_TAB     = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // Request kinds
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_FONT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_START_X    = 2'd0;
  localparam logic [1:0] REG_START_Y    = 2'd1;
  localparam logic [1:0] REG_TEXT_COLOR = 2'd2;
  localparam logic [1:0] REG_TOP_SCREEN = 2'd3;

  // Field widths
  localparam int COL_W    = 8;
  localparam int Y_W      = 10;
  localparam int SX_W     = 9;
  localparam int SY_W     = 8;
  localparam int COLOR_W  = 24;
  localparam int FADDR_W  = 11;
  localparam int OFS_W    = 19;
  localparam int SCRW_W   = 11;  // screen widths up to 1024
  localparam int PX_W     = 13;  // start_x + 255 * 16 + 7
  localparam int PY_W     = 11;  // line y + 7
  localparam int ROWOFS_W = 12;  // (rows - 1) * 3
  localparam int PROD_W   = 26;

  localparam logic [Y_W-1:0]   Y_MAX   = '1;
  localparam logic [COL_W-1:0] COL_MAX = '1;

  localparam int GLYPH_SIZE    = 8;
  localparam int GLYPH_LAST    = 7;
  localparam int BYTES_PER_PX  = 3;

  // One unit of work handed from the cursor to the cell generator
  typedef struct packed {
    logic                glyph;     // 64 cell results
    logic                font_wr;   // write one font row, one empty result
    logic [FADDR_W-1:0]  font_addr;
    logic [7:0]          font_bits;
    logic [7:0]          char_code;
    logic [PX_W-1:0]     base_x;
    logic [Y_W-1:0]      line_y;
  } job_t;

endpackage

@@ rtl/core/btr_font_mem.sv @@
// ---------------------------------------------------------------------------
// btr_font_mem
// 2048 x 8 font store, one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btr_font_mem (
  input  logic                          clk,
  input  logic                          wen,
  input  logic [btr_pkg::FADDR_W-1:0]   waddr,
  input  logic [7:0]                    wdata,
  input  logic                          ren,
  input  logic [btr_pkg::FADDR_W-1:0]   raddr,
  output logic [7:0]                    rdata
);

  logic [7:0] mem [0:(1 << btr_pkg::FADDR_W)-1];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/btr_cursor.sv @@
// ---------------------------------------------------------------------------
// btr_cursor
// Text cursor: column and line state, wrap, tab and newline handling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module btr_cursor #(
  parameter int CHAR_PITCH_X = 8,
  parameter int LINE_PITCH_Y = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          command,
  input  logic [7:0]                    char_code,
  input  logic                          string_start,
  input  logic [btr_pkg::FADDR_W-1:0]   font_address,
  input  logic [7:0]                    font_bits,
  input  logic [btr_pkg::SX_W-1:0]      start_x,
  input  logic [btr_pkg::SY_W-1:0]      start_y,
  input  logic [btr_pkg::SCRW_W-1:0]    scr_width,
  output btr_pkg::job_t                 job
);

  logic [btr_pkg::COL_W-1:0]  column_index, column_next;
  logic [btr_pkg::Y_W-1:0]    current_y, current_y_next;

  logic [btr_pkg::Y_W-1:0]    y0, y_down, y1;
  logic [btr_pkg::Y_W:0]      y_sum;
  logic [btr_pkg::COL_W-1:0]  c0, c1, c_tab, c_inc;
  logic [btr_pkg::COL_W:0]    c_tab_sum;
  logic [btr_pkg::SCRW_W-1:0] span;
  logic [btr_pkg::PX_W:0]     edge_x;
  logic                       wrap;

  always_comb begin
    y0 = string_start ? btr_pkg::Y_W'(start_y) : current_y;
    c0 = string_start ? '0 : column_index;

    y_sum  = {1'b0, y0} + (btr_pkg::Y_W + 1)'(LINE_PITCH_Y);
    y_down = (y_sum > {1'b0, btr_pkg::Y_MAX}) ? btr_pkg::Y_MAX : y_sum[btr_pkg::Y_W-1:0];

    c_tab_sum = {1'b0, c0} + (btr_pkg::COL_W + 1)'(2);
    c_tab = (c_tab_sum > {1'b0, btr_pkg::COL_MAX}) ? btr_pkg::COL_MAX
                                                   : c_tab_sum[btr_pkg::COL_W-1:0];

    // Pixels left of the right edge: wrap when column c0 would not fit.
    span = (btr_pkg::SCRW_W'(start_x) < scr_width) ?
           scr_width - btr_pkg::SCRW_W'(start_x) : '0;
    edge_x = (btr_pkg::PX_W + 1)'({1'b0, c0} + (btr_pkg::COL_W + 1)'(1)) *
             (btr_pkg::PX_W + 1)'(CHAR_PITCH_X);
    wrap = edge_x > (btr_pkg::PX_W + 1)'(span);

    c1 = wrap ? btr_pkg::COL_W'(1) : c0;
    y1 = wrap ? y_down : y0;
    c_inc = (c1 == btr_pkg::COL_MAX) ? btr_pkg::COL_MAX : c1 + btr_pkg::COL_W'(1);

    job            = '0;
    job.font_addr  = font_address;
    job.font_bits  = font_bits;
    job.char_code  = char_code;
    job.base_x     = btr_pkg::PX_W'(start_x) +
                     btr_pkg::PX_W'(btr_pkg::PX_W'(c1) * btr_pkg::PX_W'(CHAR_PITCH_X));
    job.line_y     = y1;
    column_next    = column_index;
    current_y_next = current_y;

    if (command == btr_pkg::CMD_FONT) begin
      job.font_wr = 1'b1;
      job.line_y  = current_y;
    end else if (char_code == btr_pkg::CHAR_NEWLINE) begin
      column_next    = '0;
      current_y_next = y_down;
      job.line_y     = y_down;
    end else if (char_code == btr_pkg::CHAR_TAB) begin
      column_next    = c_tab;
      current_y_next = y0;
      job.line_y     = y0;
    end else if (wrap && char_code == btr_pkg::CHAR_SPACE) begin
      // drop a space that would open the wrapped line
      column_next    = c1;
      current_y_next = y1;
    end else begin
      job.glyph      = 1'b1;
      column_next    = c_inc;
      current_y_next = y1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      current_y    <= '0;
    end else if (accept) begin
      column_index <= column_next;
      current_y    <= current_y_next;
    end
  end

endmodule

@@ rtl/core/btr_cell_gen.sv @@
// ---------------------------------------------------------------------------
// btr_cell_gen
// Steps through one job at a time, reads font rows and emits cell results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btr_cell_gen #(
  parameter int SCREEN_ROWS = 240
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          job_load,
  input  btr_pkg::job_t                 job_in,
  output logic                          in_ready,
  input  logic [btr_pkg::SCRW_W-1:0]    scr_width,
  input  logic [btr_pkg::COLOR_W-1:0]   text_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [btr_pkg::OFS_W-1:0]     out_offset,
  output logic                          out_we,
  output logic [btr_pkg::COLOR_W-1:0]   out_color,
  output logic [btr_pkg::Y_W-1:0]       out_line_y,
  output logic                          out_last
);

  localparam int ROWS3 = SCREEN_ROWS * btr_pkg::BYTES_PER_PX;

  // job slot
  logic           job_valid;
  btr_pkg::job_t  job_q;
  logic [5:0]     cnt;
  logic           advance, issue, job_done;

  // issue stage
  logic [2:0]                 row, col;
  logic [btr_pkg::PX_W-1:0]   px;
  logic [btr_pkg::PY_W-1:0]   py;
  logic                       on;
  logic                       mem_wen, mem_ren;
  logic [7:0]                 font_q;

  // cell stage
  logic                         b_valid, b_glyph, b_on, b_last;
  logic [2:0]                   b_col;
  logic [btr_pkg::PX_W-1:0]     b_px;
  logic [btr_pkg::PY_W-1:0]     b_py;
  logic [btr_pkg::Y_W-1:0]      b_line_y;
  logic                         set_bit;
  logic [btr_pkg::PROD_W-1:0]   col_ofs, ofs_sum;
  logic [btr_pkg::ROWOFS_W-1:0] row_ofs;

  assign advance  = !out_valid || out_ready;
  assign issue    = advance && job_valid;
  assign job_done = !job_q.glyph || (cnt == '1);
  assign in_ready = advance && (!job_valid || job_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      cnt       <= '0;
    end else if (advance) begin
      if (job_load) begin
        job_valid <= 1'b1;
        cnt       <= '0;
      end else if (job_valid) begin
        if (job_done) begin
          job_valid <= 1'b0;
        end else begin
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_q <= job_in;
    end
  end

  always_comb begin
    row = cnt[5:3];
    col = cnt[2:0];
    px  = job_q.base_x + btr_pkg::PX_W'(col);
    py  = btr_pkg::PY_W'(job_q.line_y) + btr_pkg::PY_W'(row);
    on  = (px < btr_pkg::PX_W'(scr_width)) && (py < btr_pkg::PY_W'(SCREEN_ROWS));
  end

  // font write runs in order with the glyph reads around it
  assign mem_wen = issue && job_q.font_wr;
  assign mem_ren = issue && job_q.glyph;

  btr_font_mem u_font (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (job_q.font_addr),
    .wdata (job_q.font_bits),
    .ren   (mem_ren),
    .raddr ({job_q.char_code, row}),
    .rdata (font_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_glyph  <= job_q.glyph;
      b_on     <= on;
      b_last   <= job_done;
      b_col    <= col;
      b_px     <= px;
      b_py     <= py;
      b_line_y <= job_q.line_y;
    end
  end

  always_comb begin
    set_bit = font_q[3'(btr_pkg::GLYPH_LAST) - b_col];
    col_ofs = btr_pkg::PROD_W'(b_px) * btr_pkg::PROD_W'(ROWS3);
    row_ofs = btr_pkg::ROWOFS_W'(btr_pkg::ROWOFS_W'(btr_pkg::PY_W'(SCREEN_ROWS - 1) - b_py) *
              btr_pkg::ROWOFS_W'(btr_pkg::BYTES_PER_PX));
    ofs_sum = col_ofs + btr_pkg::PROD_W'(row_ofs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_line_y <= b_line_y;
      out_last   <= b_last;
      if (b_glyph) begin
        out_offset <= b_on ? ofs_sum[btr_pkg::OFS_W-1:0] : '0;
        out_we     <= b_on && set_bit;
        out_color  <= text_color;
      end else begin
        out_offset <= '0;
        out_we     <= 1'b0;
        out_color  <= '0;
      end
    end
  end

  `BTR_ASSERT_IMPLY(a_wr_rd_apart, clk, rst, mem_wen, !mem_ren)
  `BTR_ASSERT_NEXT(a_empty_one_cycle, clk, rst, issue && !job_q.glyph && !job_load, !job_valid)
  `BTR_ASSERT_NEXT(a_glyph_ends_last, clk, rst, issue && job_q.glyph && cnt == '1, b_valid && b_last)

endmodule

@@ rtl/core/bitmap_text_renderer.sv @@
// A request's first result passes the job register, the cell stage and the output register.
// A glyph gives 64 cells, one per cycle unless the output stalls, as the cell counter steps the
//   font store read port; newline, tab, a dropped space and a font write each give one result.
// A new request is taken in the cycle the previous one issues its last result.
// Reset clears the cursor and pipeline, sets config defaults; font rows are undefined until written.
// ---------------------------------------------------------------------------
// bitmap_text_renderer
// Turns character requests into framebuffer pixel writes from an 8x8 font store.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_text_renderer #(
  parameter int SCREEN_ROWS  = 240,
  parameter int TOP_WIDTH    = 400,
  parameter int BOTTOM_WIDTH = 320,
  parameter int CHAR_PITCH_X = 8,
  parameter int LINE_PITCH_Y = 10
) (
  input  logic         clk,
  input  logic         rst,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // char_code[7:0], font_address[18:8], font_bits[26:19]
  input  logic [1:0]   s_axis_tuser,   // command[0], string_start[1]
  // pixel stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [55:0]  m_axis_tdata,   // byte_offset[18:0], pixel_color[42:19], line_y[52:43]
  output logic         m_axis_tuser,   // write_enable
  output logic         m_axis_tlast,
  // configuration
  input  logic         cfg_wen,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_wdata
);

  // configuration registers
  logic [btr_pkg::SX_W-1:0]    start_x;
  logic [btr_pkg::SY_W-1:0]    start_y;
  logic [btr_pkg::COLOR_W-1:0] text_color;
  logic                        top_screen;

  logic [btr_pkg::SCRW_W-1:0]  scr_width;
  logic                        accept;
  btr_pkg::job_t               job;

  logic [btr_pkg::OFS_W-1:0]   out_offset;
  logic [btr_pkg::COLOR_W-1:0] out_color;
  logic [btr_pkg::Y_W-1:0]     out_line_y;

  // The user must write these only while idle; the block does not enforce it, and the datapath reads these live.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      text_color <= '1;
      top_screen <= 1'b1;
    end else if (cfg_wen) begin
      case (cfg_index)
        btr_pkg::REG_START_X:    start_x    <= cfg_wdata[btr_pkg::SX_W-1:0];
        btr_pkg::REG_START_Y:    start_y    <= cfg_wdata[btr_pkg::SY_W-1:0];
        btr_pkg::REG_TEXT_COLOR: text_color <= cfg_wdata;
        btr_pkg::REG_TOP_SCREEN: top_screen <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign scr_width = top_screen ? btr_pkg::SCRW_W'(TOP_WIDTH) : btr_pkg::SCRW_W'(BOTTOM_WIDTH);
  assign accept    = s_axis_tvalid && s_axis_tready;

  // Cursor: decide what the request does and advance column and line on accept.
  btr_cursor #(
    .CHAR_PITCH_X (CHAR_PITCH_X),
    .LINE_PITCH_Y (LINE_PITCH_Y)
  ) u_cursor (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .command      (s_axis_tuser[0]),
    .char_code    (s_axis_tdata[7:0]),
    .string_start (s_axis_tuser[1]),
    .font_address (s_axis_tdata[18:8]),
    .font_bits    (s_axis_tdata[26:19]),
    .start_x      (start_x),
    .start_y      (start_y),
    .scr_width    (scr_width),
    .job          (job)
  );

  // Cell generator: holds the job, walks the font store and drives the output register.
  btr_cell_gen #(
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_cells (
    .clk        (clk),
    .rst        (rst),
    .job_load   (accept),
    .job_in     (job),
    .in_ready   (s_axis_tready),
    .scr_width  (scr_width),
    .text_color (text_color),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_offset (out_offset),
    .out_we     (m_axis_tuser),
    .out_color  (out_color),
    .out_line_y (out_line_y),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_line_y, out_color, out_offset};

endmodule
